FILE: hw/rtl/mwsl_pkg.sv
// Mecanum wheel speed limiter: shared widths, codes, reset values and constants.
// No dependencies.
package mwsl_pkg;

    localparam int CMD_W      = 16;
    localparam int WHL_W      = 24;
    localparam int LEVER_W    = 12;
    localparam int INV_W      = 24;
    localparam int MAX_W      = 23;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int NUM_WHEELS = 4;

    // signed wheel-edge sum in 0.001 mm/s and its magnitude
    localparam int SUM_W  = 29;
    localparam int MAG_W  = SUM_W - 1;
    localparam int PROD_W = MAG_W + INV_W;

    // rounding: (p + 500 * 2^16) / (2^16 * 1000), then / 8 / 125
    localparam int FRAC_SHIFT = 16;
    localparam int Y_W        = PROD_W - FRAC_SHIFT + 1;
    localparam int OCT_SHIFT  = 3;
    localparam int Z_W        = Y_W - OCT_SHIFT;
    localparam int ROUND_BIAS = 500;

    // divide by 125 through a reciprocal, one correction step
    localparam int RECIP_DIV   = 125;
    localparam int RECIP_SHIFT = Z_W;
    localparam int RECIP_W     = 28;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / RECIP_DIV);
    localparam int Z_LO_W      = Z_W / 2;
    localparam int Z_HI_W      = Z_W - Z_LO_W;
    localparam int PP_W        = Z_HI_W + RECIP_W;
    localparam int PSUM_W      = Z_W + RECIP_W;
    localparam int RES_W       = 8;

    localparam int RAW_W  = 27;
    localparam int QUO_W  = MAX_W;
    localparam int NUM_W  = RAW_W + MAX_W;

    localparam int FRONT_STAGES = 9;
    localparam int DIV_STEPS    = QUO_W;
    localparam int NUM_STAGES   = FRONT_STAGES + DIV_STEPS + 1;

    // wheels reported in negated form
    localparam logic [NUM_WHEELS-1:0] WHEEL_FLIP = 4'b1010;

    localparam logic signed [SUM_W-1:0] SPEED_SCALE = SUM_W'(1000);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEVER_ARM  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_RADIUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED  = 2'd2;

    localparam logic [LEVER_W-1:0] LEVER_ARM_RST  = LEVER_W'(400);
    localparam logic [INV_W-1:0]   INV_RADIUS_RST = INV_W'(862316);
    localparam logic [MAX_W-1:0]   MAX_SPEED_RST  = MAX_W'(31416);

    typedef logic signed [CMD_W-1:0] cmd_speed_t;
    typedef logic signed [WHL_W-1:0] wheel_speed_t;
    typedef logic [CFG_IDX_W-1:0]    cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]   cfg_data_t;

endpackage

FILE: hw/rtl/mwsl_if.sv
// Channel interfaces of the mecanum wheel speed limiter: command, wheel speeds, config.
// Depends on mwsl_pkg.
interface mwsl_cmd_if
    import mwsl_pkg::*;
();
    logic       valid;
    logic       ready;
    cmd_speed_t forward_speed;
    cmd_speed_t lateral_speed;
    cmd_speed_t turn_rate;

    modport source (output valid, output forward_speed, output lateral_speed,
                    output turn_rate, input ready);
    modport sink   (input valid, input forward_speed, input lateral_speed,
                    input turn_rate, output ready);
endinterface

interface mwsl_whl_if
    import mwsl_pkg::*;
();
    logic         valid;
    logic         ready;
    wheel_speed_t wheel_speed_0;
    wheel_speed_t wheel_speed_1;
    wheel_speed_t wheel_speed_2;
    wheel_speed_t wheel_speed_3;
    logic         was_limited;

    modport source (output valid, output wheel_speed_0, output wheel_speed_1,
                    output wheel_speed_2, output wheel_speed_3, output was_limited,
                    input ready);
    modport sink   (input valid, input wheel_speed_0, input wheel_speed_1,
                    input wheel_speed_2, input wheel_speed_3, input was_limited,
                    output ready);
endinterface

interface mwsl_cfg_if
    import mwsl_pkg::*;
();
    logic       valid;
    logic       ready;
    cfg_index_t index;
    cfg_data_t  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/mecanum_wheel_speed_limiter.sv
// Mecanum wheel speed limiter top level: inverse kinematics, rounding, limiting.
// Depends on mwsl_pkg and the interfaces in mwsl_if.
//
// Usage:
//   cmd    : body velocity beats (forward, lateral, turn rate), valid/ready.
//   wheels : one beat per command, four wheel speeds and was_limited, valid/ready.
//   cfg    : register writes (lever arm, inverse radius, speed limit); always ready.
//            Write only while no command is in flight.
// Throughput: one command per cycle unless the output stalls (see Stall). A result
//   passes through the arithmetic stages, then the 23-step restoring divider (one
//   quotient bit per stage), then the output register that drives wheels.valid.
// Reset: pipeline empties, registers take their default values; cmd.ready is
//   high straight out of reset.
// Stall: the output register holds its beat until taken. The pipeline keeps
//   moving and accepting until its last stage holds a result as well; only then
//   does cmd.ready drop.
module mecanum_wheel_speed_limiter
    import mwsl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mwsl_cmd_if.sink    cmd,
    mwsl_whl_if.source  wheels,
    mwsl_cfg_if.sink    cfg
);

    localparam int ST_CORR = 5;
    localparam int ST_MAX  = 8;

    logic [LEVER_W-1:0] lever_reg;
    logic [INV_W-1:0]   inv_reg;
    logic [MAX_W-1:0]   max_reg;

    logic [NUM_STAGES-1:0] vld_reg;
    logic                  out_valid_reg;
    logic                  adv;

    // stage 1
    logic signed [SUM_W-1:0] rot_reg, fwd_reg, lat_reg;
    logic signed [SUM_W-1:0] rot_next, fwd_next, lat_next;
    // stage 2
    logic [MAG_W-1:0]      mag_reg [NUM_WHEELS];
    logic [MAG_W-1:0]      mag_next [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] neg2_reg, neg2_next;
    logic signed [SUM_W-1:0] sum_w [NUM_WHEELS];
    // stage 3
    logic [PROD_W-1:0]     prod_reg [NUM_WHEELS];
    logic [PROD_W-1:0]     prod_next [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] neg3_reg;
    // stage 4
    logic [Z_W-1:0]        z_reg [NUM_WHEELS];
    logic [Z_W-1:0]        z_next [NUM_WHEELS];
    logic [Y_W-1:0]        y_w [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] neg4_reg;
    // stage 5
    logic [PP_W-1:0]       phi_reg [NUM_WHEELS];
    logic [PP_W-1:0]       plo_reg [NUM_WHEELS];
    logic [PP_W-1:0]       phi_next [NUM_WHEELS];
    logic [PP_W-1:0]       plo_next [NUM_WHEELS];
    logic [RES_W-1:0]      z5_reg [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] neg5_reg;
    // stage 6
    logic [RAW_W-1:0]      qe_reg [NUM_WHEELS];
    logic [RAW_W-1:0]      qe_next [NUM_WHEELS];
    logic [PSUM_W-1:0]     psum_w [NUM_WHEELS];
    logic [RES_W-1:0]      z6_reg [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] neg6_reg;
    // stage 7
    logic [RAW_W-1:0]      raw7_reg [NUM_WHEELS];
    logic [RAW_W-1:0]      raw7_next [NUM_WHEELS];
    logic [RES_W-1:0]      r8_w [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] neg7_reg;
    // stage 8
    logic [RAW_W-1:0]      mx_reg [2];
    logic [RAW_W-1:0]      mx_next [2];
    logic [RAW_W-1:0]      raw8_reg [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] neg8_reg;
    // stage 9
    logic [RAW_W-1:0]      mmax_reg, mmax_next;
    logic [RAW_W-1:0]      raw9_reg [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] neg9_reg;
    // divider, index 0 is the loading stage
    logic [RAW_W-1:0]      rem_reg  [DIV_STEPS+1][NUM_WHEELS];
    logic [RAW_W-1:0]      rem_next [DIV_STEPS+1][NUM_WHEELS];
    logic [DIV_STEPS-1:0]  low_reg  [DIV_STEPS][NUM_WHEELS];
    logic [DIV_STEPS-1:0]  low_next [DIV_STEPS][NUM_WHEELS];
    logic [QUO_W-1:0]      quo_reg  [DIV_STEPS+1][NUM_WHEELS];
    logic [QUO_W-1:0]      quo_next [DIV_STEPS+1][NUM_WHEELS];
    logic [QUO_W-1:0]      draw_reg [DIV_STEPS+1][NUM_WHEELS];
    logic [RAW_W-1:0]      dm_reg   [DIV_STEPS+1];
    logic                  dlim_reg [DIV_STEPS+1];
    logic [NUM_WHEELS-1:0] dneg_reg [DIV_STEPS+1];
    logic [NUM_W-1:0]      num_w [NUM_WHEELS];
    logic                  lim_next;
    // output
    wheel_speed_t          ws_reg  [NUM_WHEELS];
    wheel_speed_t          ws_next [NUM_WHEELS];
    logic                  lim_out_reg;

    assign adv       = !(vld_reg[NUM_STAGES-1] && out_valid_reg && !wheels.ready);
    assign cmd.ready = adv;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lever_reg <= LEVER_ARM_RST;
            inv_reg   <= INV_RADIUS_RST;
            max_reg   <= MAX_SPEED_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_LEVER_ARM:  lever_reg <= cfg.data[LEVER_W-1:0];
                REG_INV_RADIUS: inv_reg   <= cfg.data[INV_W-1:0];
                REG_MAX_SPEED:  max_reg   <= cfg.data[MAX_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= {vld_reg[NUM_STAGES-2:0], cmd.valid};
            end
            if (adv && vld_reg[NUM_STAGES-1])
            begin
                out_valid_reg <= 1'b1;
            end
            else if (wheels.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        rot_next = SUM_W'($signed({1'b0, lever_reg})) * SUM_W'(cmd.turn_rate);
        fwd_next = SUM_W'(cmd.forward_speed) * SPEED_SCALE;
        lat_next = SUM_W'(cmd.lateral_speed) * SPEED_SCALE;

        sum_w[0] = fwd_reg - rot_reg - lat_reg;
        sum_w[1] = fwd_reg + rot_reg + lat_reg;
        sum_w[2] = fwd_reg - rot_reg + lat_reg;
        sum_w[3] = fwd_reg + rot_reg - lat_reg;

        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            mag_next[w]  = sum_w[w][SUM_W-1] ? MAG_W'(-sum_w[w]) : MAG_W'(sum_w[w]);
            neg2_next[w] = sum_w[w][SUM_W-1] ^ WHEEL_FLIP[w];

            prod_next[w] = PROD_W'(mag_reg[w]) * PROD_W'(inv_reg);

            y_w[w]    = Y_W'(prod_reg[w][PROD_W-1:FRAC_SHIFT]) + Y_W'(ROUND_BIAS);
            z_next[w] = y_w[w][Y_W-1:OCT_SHIFT];

            phi_next[w] = PP_W'(z_reg[w][Z_W-1:Z_LO_W]) * PP_W'(RECIP);
            plo_next[w] = PP_W'(z_reg[w][Z_LO_W-1:0]) * PP_W'(RECIP);

            psum_w[w]  = (PSUM_W'(phi_reg[w]) << Z_LO_W) + PSUM_W'(plo_reg[w]);
            qe_next[w] = psum_w[w][RECIP_SHIFT +: RAW_W];

            // remainder fits in eight bits since the estimate is at most one low
            r8_w[w]      = z6_reg[w] - RES_W'(qe_reg[w][RES_W-1:0] * RES_W'(RECIP_DIV));
            raw7_next[w] = qe_reg[w] + RAW_W'(r8_w[w] >= RES_W'(RECIP_DIV));
        end

        mx_next[0] = (raw7_reg[0] > raw7_reg[1]) ? raw7_reg[0] : raw7_reg[1];
        mx_next[1] = (raw7_reg[2] > raw7_reg[3]) ? raw7_reg[2] : raw7_reg[3];
        mmax_next  = (mx_reg[0] > mx_reg[1]) ? mx_reg[0] : mx_reg[1];

        lim_next = mmax_reg > RAW_W'(max_reg);
        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            num_w[w]       = NUM_W'(raw9_reg[w]) * NUM_W'(max_reg);
            rem_next[0][w] = num_w[w][NUM_W-1:DIV_STEPS];
            low_next[0][w] = num_w[w][DIV_STEPS-1:0];
            quo_next[0][w] = '0;
        end

        for (int d = 1; d <= DIV_STEPS; d++)
        begin
            for (int w = 0; w < NUM_WHEELS; w++)
            begin
                logic [RAW_W:0] trial;
                logic           ge;
                trial = {rem_reg[d-1][w], low_reg[d-1][w][DIV_STEPS-1]};
                ge    = trial >= {1'b0, dm_reg[d-1]};
                rem_next[d][w] = ge ? RAW_W'(trial - {1'b0, dm_reg[d-1]}) : RAW_W'(trial);
                quo_next[d][w] = {quo_reg[d-1][w][QUO_W-2:0], ge};
                if (d < DIV_STEPS)
                begin
                    low_next[d][w] = low_reg[d-1][w] << 1;
                end
            end
        end

        for (int w = 0; w < NUM_WHEELS; w++)
        begin
            logic [QUO_W-1:0] val;
            val = dlim_reg[DIV_STEPS] ? quo_reg[DIV_STEPS][w] : draw_reg[DIV_STEPS][w];
            ws_next[w] = dneg_reg[DIV_STEPS][w] ? -WHL_W'(val) : WHL_W'(val);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rot_reg  <= rot_next;
            fwd_reg  <= fwd_next;
            lat_reg  <= lat_next;
            neg2_reg <= neg2_next;
            neg3_reg <= neg2_reg;
            neg4_reg <= neg3_reg;
            neg5_reg <= neg4_reg;
            neg6_reg <= neg5_reg;
            neg7_reg <= neg6_reg;
            neg8_reg <= neg7_reg;
            neg9_reg <= neg8_reg;
            mx_reg   <= mx_next;
            mmax_reg <= mmax_next;
            for (int w = 0; w < NUM_WHEELS; w++)
            begin
                mag_reg[w]  <= mag_next[w];
                prod_reg[w] <= prod_next[w];
                z_reg[w]    <= z_next[w];
                phi_reg[w]  <= phi_next[w];
                plo_reg[w]  <= plo_next[w];
                z5_reg[w]   <= z_reg[w][RES_W-1:0];
                qe_reg[w]   <= qe_next[w];
                z6_reg[w]   <= z5_reg[w];
                raw7_reg[w] <= raw7_next[w];
                raw8_reg[w] <= raw7_reg[w];
                raw9_reg[w] <= raw8_reg[w];
            end

            dm_reg[0]   <= mmax_reg;
            dlim_reg[0] <= lim_next;
            dneg_reg[0] <= neg9_reg;
            for (int w = 0; w < NUM_WHEELS; w++)
            begin
                draw_reg[0][w] <= raw9_reg[w][QUO_W-1:0];
            end
            for (int d = 0; d <= DIV_STEPS; d++)
            begin
                rem_reg[d] <= rem_next[d];
                quo_reg[d] <= quo_next[d];
                if (d < DIV_STEPS)
                begin
                    low_reg[d] <= low_next[d];
                end
                if (d > 0)
                begin
                    dm_reg[d]   <= dm_reg[d-1];
                    dlim_reg[d] <= dlim_reg[d-1];
                    dneg_reg[d] <= dneg_reg[d-1];
                    draw_reg[d] <= draw_reg[d-1];
                end
            end

            if (vld_reg[NUM_STAGES-1])
            begin
                ws_reg      <= ws_next;
                lim_out_reg <= dlim_reg[DIV_STEPS];
            end
        end
    end

    assign wheels.valid         = out_valid_reg;
    assign wheels.wheel_speed_0 = ws_reg[0];
    assign wheels.wheel_speed_1 = ws_reg[1];
    assign wheels.wheel_speed_2 = ws_reg[2];
    assign wheels.wheel_speed_3 = ws_reg[3];
    assign wheels.was_limited   = lim_out_reg;

    // input only blocks when both the last stage and the output register are full
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> (vld_reg[NUM_STAGES-1] && out_valid_reg))
        else $error("cmd.ready low with room in the pipeline");

    // reciprocal estimate is never more than one short
    a_recip_corr: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_CORR] |->
            (r8_w[0] < RES_W'(2 * RECIP_DIV)) && (r8_w[1] < RES_W'(2 * RECIP_DIV)) &&
            (r8_w[2] < RES_W'(2 * RECIP_DIV)) && (r8_w[3] < RES_W'(2 * RECIP_DIV)))
        else $error("divide-by-125 estimate off by more than one");

    a_max_tree: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_MAX] |->
            (raw9_reg[0] <= mmax_reg) && (raw9_reg[1] <= mmax_reg) &&
            (raw9_reg[2] <= mmax_reg) && (raw9_reg[3] <= mmax_reg))
        else $error("wheel magnitude above the computed maximum");

    // restoring divider keeps its remainder below the divisor on limited beats
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NUM_STAGES-1] && dlim_reg[DIV_STEPS]) |->
            (rem_reg[DIV_STEPS][0] < dm_reg[DIV_STEPS]) &&
            (rem_reg[DIV_STEPS][1] < dm_reg[DIV_STEPS]) &&
            (rem_reg[DIV_STEPS][2] < dm_reg[DIV_STEPS]) &&
            (rem_reg[DIV_STEPS][3] < dm_reg[DIV_STEPS]))
        else $error("divider remainder not below divisor");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for mecanum_wheel_speed_limiter: directed probe table, then random
// commands over several register settings, checked against a fixed-point wheel predictor.
// Depends on mwsl_pkg, the mwsl_if interfaces and the RTL top level.
module testbench;
    import mwsl_pkg::*;

    localparam int          CLK_HALF      = 6;
    localparam int          RESET_CYCLES  = 8;
    localparam int          RANDOM_PHASES = 10;
    localparam int          PHASE_ITEMS   = 150;
    localparam int          TAIL_CYCLES   = 48;
    localparam int          CYCLE_LIMIT   = 500000;
    localparam int          NUM_PROBES    = 25;
    localparam longint unsigned SPEED_DIV = 64'd65536000;
    localparam longint unsigned HALF_DIV  = 64'd32768000;
    localparam logic [NUM_WHEELS-1:0] NEGATED_WHEELS = 4'b1010;

    typedef struct packed {
        wheel_speed_t [NUM_WHEELS-1:0] spd;
        logic                          limited;
    } wheel_set_t;

    typedef struct packed {
        int lever;
        int inv_radius;
        int speed_cap;
        int fw;
        int lt;
        int tr;
        int pinned;
        int w0;
        int w1;
        int w2;
        int w3;
        int limited;
    } probe_row_t;

    typedef enum logic [1:0] {RX_OPEN, RX_SPARSE, RX_EVERY_THIRD, RX_CHOKED} rx_mode_t;

    // register settings first, then command, then pinned result where obvious
    localparam probe_row_t PROBES [NUM_PROBES] = '{
        '{400, 862316, 31416, 0, 0, 0, 1, 0, 0, 0, 0, 0},
        '{400, 862316, 31416, 32767, 32767, 32767, 0, 0, 0, 0, 0, 0},
        '{400, 862316, 31416, -32768, -32768, -32768, 0, 0, 0, 0, 0, 0},
        '{400, 862316, 31416, 32767, -32768, 0, 0, 0, 0, 0, 0, 0},
        '{400, 862316, 31416, 0, 0, -32768, 0, 0, 0, 0, 0, 0},
        '{400, 862316, 31416, 1000, 0, 0, 0, 0, 0, 0, 0, 0},
        '{400, 862316, 31416, 100, -50, 300, 0, 0, 0, 0, 0, 0},
        '{0, 65536, 8388607, 100, 0, 0, 1, 100, -100, 100, -100, 0},
        '{0, 65536, 8388607, 0, 100, 0, 1, -100, -100, 100, 100, 0},
        '{0, 65536, 8388607, 0, 0, 32767, 1, 0, 0, 0, 0, 0},
        '{0, 65536, 8388607, -32768, -32768, -32768, 1, 0, 65536, -65536, 0, 0},
        '{1000, 65536, 8388607, 0, 0, 100, 1, -100, -100, -100, -100, 0},
        '{1, 65536, 8388607, 0, 0, 500, 1, -1, -1, -1, -1, 0},
        '{1, 65536, 8388607, 0, 0, 499, 1, 0, 0, 0, 0, 0},
        '{1, 65536, 8388607, 0, 0, -500, 1, 1, 1, 1, 1, 0},
        '{0, 65536, 100, 100, 0, 0, 1, 100, -100, 100, -100, 0},
        '{0, 65536, 99, 100, 0, 0, 1, 99, -99, 99, -99, 1},
        '{0, 65536, 99, 100, 50, 0, 0, 0, 0, 0, 0, 0},
        '{0, 65536, 0, 1, 0, 0, 1, 0, 0, 0, 0, 1},
        '{0, 65536, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0},
        '{4095, 0, 8388607, 32767, -32768, 32767, 1, 0, 0, 0, 0, 0},
        '{4095, 16777215, 8388607, 32767, 32767, 32767, 0, 0, 0, 0, 0, 0},
        '{4095, 16777215, 8388607, -32768, 32767, -32768, 0, 0, 0, 0, 0, 0},
        '{4095, 16777215, 8388607, 32767, -32768, -32768, 0, 0, 0, 0, 0, 0},
        '{4095, 16777215, 0, -32768, -32768, 32767, 1, 0, 0, 0, 0, 1}
    };

    logic clk;
    logic rst_n;

    mwsl_cmd_if cmd_if ();
    mwsl_whl_if whl_if ();
    mwsl_cfg_if cfg_if ();

    mecanum_wheel_speed_limiter u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_if),
        .wheels (whl_if),
        .cfg    (cfg_if)
    );

    logic [LEVER_W-1:0] lever_q;
    logic [INV_W-1:0]   inv_q;
    logic [MAX_W-1:0]   cap_q;

    wheel_set_t setpoints_due [$];
    int         commands_sent     = 0;
    int         setpoints_checked = 0;
    int         limited_seen      = 0;
    int         settings_used     = 1;
    int         faults            = 0;
    int         cycle_count       = 0;
    int         burst_left        = 0;
    rx_mode_t   rx_mode           = RX_OPEN;
    int         rx_run            = 0;
    int         rx_tick           = 0;

    initial clk = 1'b0;
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic wheel_set_t predict_wheels(cmd_speed_t fw, cmd_speed_t lt,
                                                  cmd_speed_t tr);
        wheel_set_t      res;
        longint          rim_sum [NUM_WHEELS];
        longint          spd [NUM_WHEELS];
        longint          rot;
        longint          fwd_um;
        longint          lat_um;
        longint unsigned mag;
        longint unsigned peak;
        longint unsigned q;
        int              i;
        rot        = longint'(lever_q) * longint'(tr);
        fwd_um     = longint'(fw) * 1000;
        lat_um     = longint'(lt) * 1000;
        rim_sum[0] = -rot + fwd_um - lat_um;
        rim_sum[1] =  rot + fwd_um + lat_um;
        rim_sum[2] = -rot + fwd_um + lat_um;
        rim_sum[3] =  rot + fwd_um - lat_um;
        peak = 0;
        for (i = 0; i < NUM_WHEELS; i++)
        begin
            // round to nearest, ties away from zero, on the magnitude
            mag    = (rim_sum[i] < 0) ? -rim_sum[i] : rim_sum[i];
            q      = (mag * inv_q + HALF_DIV) / SPEED_DIV;
            spd[i] = (rim_sum[i] < 0) ? -longint'(q) : longint'(q);
            if (NEGATED_WHEELS[i])
                spd[i] = -spd[i];
            mag = (spd[i] < 0) ? -spd[i] : spd[i];
            if (mag > peak)
                peak = mag;
        end
        res.limited = (peak > cap_q);
        for (i = 0; i < NUM_WHEELS; i++)
        begin
            if (res.limited)
            begin
                mag    = (spd[i] < 0) ? -spd[i] : spd[i];
                q      = mag * cap_q / peak;
                spd[i] = (spd[i] < 0) ? -longint'(q) : longint'(q);
            end
            res.spd[i] = wheel_speed_t'(spd[i]);
        end
        return res;
    endfunction

    function automatic cmd_speed_t pick_speed();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            return cmd_speed_t'($urandom);
        if (roll < 7)
            return cmd_speed_t'(int'($urandom_range(0, 8000)) - 4000);
        if (roll < 9)
        begin
            case ($urandom_range(0, 4))
                0:       return cmd_speed_t'(-32768);
                1:       return cmd_speed_t'(-1);
                2:       return cmd_speed_t'(0);
                3:       return cmd_speed_t'(1);
                default: return cmd_speed_t'(32767);
            endcase
        end
        return cmd_speed_t'(int'($urandom_range(0, 100)) - 50);
    endfunction

    task automatic write_register(cfg_index_t idx, cfg_data_t value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (idx)
            REG_LEVER_ARM:  lever_q = LEVER_W'(value);
            REG_INV_RADIUS: inv_q   = INV_W'(value);
            REG_MAX_SPEED:  cap_q   = MAX_W'(value);
            default:        ;
        endcase
        @(negedge clk);
    endtask

    // back-to-back beats on cfg, valid dropped only after the last
    task automatic set_limits(int lever, int inv_radius, int speed_cap);
        write_register(REG_LEVER_ARM, cfg_data_t'(lever));
        write_register(REG_INV_RADIUS, cfg_data_t'(inv_radius));
        write_register(REG_MAX_SPEED, cfg_data_t'(speed_cap));
        cfg_if.valid <= 1'b0;
        settings_used++;
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 8));
            if (gap != 0)
            begin
                cmd_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
    endtask

    task automatic send_command(cmd_speed_t fw, cmd_speed_t lt, cmd_speed_t tr,
                                bit pinned, wheel_set_t pinned_set);
        cmd_if.valid         <= 1'b1;
        cmd_if.forward_speed <= fw;
        cmd_if.lateral_speed <= lt;
        cmd_if.turn_rate     <= tr;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        setpoints_due.push_back(pinned ? pinned_set : predict_wheels(fw, lt, tr));
        commands_sent++;
        @(negedge clk);
    endtask

    task automatic drain_setpoints();
        cmd_if.valid <= 1'b0;
        while (setpoints_due.size() != 0)
            @(negedge clk);
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (rx_run == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_run  = $urandom_range(16, 160);
        end
        rx_run--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:        whl_if.ready <= 1'b1;
            RX_SPARSE:      whl_if.ready <= ($urandom_range(0, 3) != 0);
            RX_EVERY_THIRD: whl_if.ready <= (rx_tick % 3 == 0);
            default:        whl_if.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        wheel_set_t   due;
        wheel_speed_t seen [NUM_WHEELS];
        int           i;
        if (rst_n && whl_if.valid && whl_if.ready)
        begin
            if (setpoints_due.size() == 0)
            begin
                $display("%0t: wheel beat with nothing outstanding: %0d %0d %0d %0d lim %0b",
                         $time, whl_if.wheel_speed_0, whl_if.wheel_speed_1,
                         whl_if.wheel_speed_2, whl_if.wheel_speed_3, whl_if.was_limited);
                faults++;
            end
            else
            begin
                due     = setpoints_due.pop_front();
                seen[0] = whl_if.wheel_speed_0;
                seen[1] = whl_if.wheel_speed_1;
                seen[2] = whl_if.wheel_speed_2;
                seen[3] = whl_if.wheel_speed_3;
                for (i = 0; i < NUM_WHEELS; i++)
                begin
                    if (seen[i] !== due.spd[i])
                    begin
                        $display("%0t: wheel_speed_%0d expected %0d, got %0d", $time, i,
                                 $signed(due.spd[i]), $signed(seen[i]));
                        faults++;
                    end
                end
                if (whl_if.was_limited !== due.limited)
                begin
                    $display("%0t: was_limited expected %0b, got %0b", $time,
                             due.limited, whl_if.was_limited);
                    faults++;
                end
                setpoints_checked++;
                if (whl_if.was_limited === 1'b1)
                    limited_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timed out, %0d wheel beats outstanding", $time,
                     setpoints_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        probe_row_t row;
        wheel_set_t pinned_set;
        int         p;
        int         n;
        int         lever;
        int         inv_radius;
        int         speed_cap;
        rst_n                = 1'b0;
        cmd_if.valid         = 1'b0;
        cmd_if.forward_speed = '0;
        cmd_if.lateral_speed = '0;
        cmd_if.turn_rate     = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = REG_LEVER_ARM;
        cfg_if.data          = '0;
        lever_q              = LEVER_W'(400);
        inv_q                = INV_W'(862316);
        cap_q                = MAX_W'(31416);
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (p = 0; p < NUM_PROBES; p++)
        begin
            row = PROBES[p];
            if (LEVER_W'(row.lever) != lever_q || INV_W'(row.inv_radius) != inv_q ||
                MAX_W'(row.speed_cap) != cap_q)
            begin
                drain_setpoints();
                set_limits(row.lever, row.inv_radius, row.speed_cap);
            end
            pinned_set.spd[0]  = wheel_speed_t'(row.w0);
            pinned_set.spd[1]  = wheel_speed_t'(row.w1);
            pinned_set.spd[2]  = wheel_speed_t'(row.w2);
            pinned_set.spd[3]  = wheel_speed_t'(row.w3);
            pinned_set.limited = (row.limited != 0);
            pace_sender();
            send_command(cmd_speed_t'(row.fw), cmd_speed_t'(row.lt), cmd_speed_t'(row.tr),
                         row.pinned != 0, pinned_set);
        end

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    lever = 400; inv_radius = 862316; speed_cap = 31416;
                end
                1:
                begin
                    lever = 4095; inv_radius = 16777215; speed_cap = 8388607;
                end
                2:
                begin
                    lever = 0; inv_radius = 0; speed_cap = 0;
                end
                3:
                begin
                    lever = 4095; inv_radius = 16777215; speed_cap = 0;
                end
                4:
                begin
                    lever = 0; inv_radius = 65536; speed_cap = $urandom_range(0, 40000);
                end
                default:
                begin
                    lever      = $urandom_range(0, 4095);
                    inv_radius = $urandom_range(0, 24'hFFFFFF);
                    speed_cap  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 23'h7FFFFF)
                                                             : $urandom_range(0, 60000);
                end
            endcase
            drain_setpoints();
            set_limits(lever, inv_radius, speed_cap);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                pace_sender();
                send_command(pick_speed(), pick_speed(), pick_speed(), 1'b0, pinned_set);
            end
        end

        drain_setpoints();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("Sent %0d commands over %0d register settings.",
                 commands_sent, settings_used);
        $display("%0d wheel beats checked, %0d limited, %0d faults.",
                 setpoints_checked, limited_seen, faults);
        if (faults == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
